>>> src/deq_pkg.sv
// shared constants, codes and types of the double-ended queue
package deq_pkg;

  // storage and field widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 7;

  // operation codes of an input item
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

  // status codes of a result
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_ROTATE
  } cell_op_e;

  // value carries the pushed word, or the front word during a rotate
  typedef struct packed {
    cell_op_e                   op;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_e;

endpackage

>>> src/deq_in_if.sv
// input channel: operation items
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::MODE_W-1:0]          mode;
  logic signed [deq_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, mode, push_value, input ready);
  modport sink   (input valid, mode, push_value, output ready);
endinterface

>>> src/deq_out_if.sv
// output channel: result items
interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   element;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic [deq_pkg::OCC_W-1:0]           occupancy;
  logic                                last;

  modport source (output valid, element, status, occupancy, last, input ready);
  modport sink   (input valid, element, status, occupancy, last, output ready);
endinterface

>>> src/deq_cell.sv
// one storage cell of the queue chain, element i counted from the front
module deq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::cell_ctl_t                ctl_i,
  input  logic signed [deq_pkg::DATA_W-1:0] left_data_i,
  input  logic                              left_occ_i,
  input  logic signed [deq_pkg::DATA_W-1:0] right_data_i,
  input  logic                              right_occ_i,
  output logic signed [deq_pkg::DATA_W-1:0] data_o,
  output logic                              occ_o,
  output logic signed [deq_pkg::DATA_W-1:0] tap_o
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     occ_q, occ_d;
  logic                     is_back;

  // this cell holds the back element
  assign is_back = occ_q && !right_occ_i;

  // next state from the broadcast command and the neighbors
  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    unique case (ctl_i.op)
      OP_PUSH_FRONT: begin
        data_d = left_data_i;
        occ_d  = left_occ_i;
      end
      OP_POP_FRONT: begin
        data_d = right_data_i;
        occ_d  = right_occ_i;
      end
      OP_PUSH_BACK: begin
        if (!occ_q && left_occ_i) begin
          data_d = ctl_i.value;
          occ_d  = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_back) begin
          occ_d = 1'b0;
        end
      end
      OP_ROTATE: begin
        if (right_occ_i) begin
          data_d = right_data_i;
        end else if (occ_q) begin
          data_d = ctl_i.value;
        end
      end
      default: begin
        data_d = data_q;
        occ_d  = occ_q;
      end
    endcase
  end

  // occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // stored word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  assign tap_o  = is_back ? data_q : '0;

endmodule

>>> src/double_ended_queue.sv
// top level of the bounded double-ended queue built as a shifting cell chain
//
//   channel | dir | payload                              | transfer when
//   in_i    | in  | mode, push_value                     | valid && ready
//   out_o   | out | element, status, occupancy, last     | valid && ready
//
// push, pop and unused codes: one result; the next item is taken once the result register is free
// list of n elements: n results after the accepting cycle, the chain rotates
//   one place per transfer so the front cell feeds the output
// input is held while a list runs; a result register parts the two sides
// a stalled output freezes the chain and the controller
// reset clears the occupied flags and the count; stored words need none
module double_ended_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  deq_in_if.sink   in_i,
  deq_out_if.source out_o
);
  import deq_pkg::*;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         remain_q, remain_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_elem_q, out_elem_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic [OCC_W-1:0]         out_occ_q, out_occ_d;
  logic                     out_last_q, out_last_d;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];
  logic [CAPACITY-1:0]      cell_occ;
  logic signed [DATA_W-1:0] back_data;

  logic                     out_free;
  logic                     accept;
  logic                     is_full;
  logic                     is_empty;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data, right_data;
    logic                     left_occ, right_occ;
    if (i == 0) begin : g_head
      assign left_data = ctl.value;
      assign left_occ  = 1'b1;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end
    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .left_data_i  (left_data),
      .left_occ_i   (left_occ),
      .right_data_i (right_data),
      .right_occ_i  (right_occ),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .tap_o        (cell_tap[i])
    );
  end

  // back element: only the back cell drives a nonzero tap
  always_comb begin
    back_data = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      back_data = back_data | cell_tap[k];
    end
  end

  // controller and result register
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    ctl.op       = OP_HOLD;
    ctl.value    = in_i.push_value;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_elem_d   = out_elem_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_elem_d   = '0;
          out_status_d = STATUS_DONE;
          out_last_d   = 1'b1;
          unique case (in_i.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (is_full) begin
                out_status_d = STATUS_FULL;
              end else begin
                ctl.op  = (in_i.mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                count_d = count_q + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (is_empty) begin
                out_status_d = STATUS_EMPTY;
              end else begin
                ctl.op     = OP_POP_FRONT;
                out_elem_d = cell_data[0];
                count_d    = count_q - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (is_empty) begin
                out_status_d = STATUS_EMPTY;
              end else begin
                ctl.op     = OP_POP_BACK;
                out_elem_d = back_data;
                count_d    = count_q - 1'b1;
              end
            end
            MODE_LIST: begin
              if (is_empty) begin
                out_status_d = STATUS_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                remain_d    = count_q;
                state_d     = ST_LIST;
              end
            end
            default: begin
              out_status_d = STATUS_DONE;
            end
          endcase
          out_occ_d = OCC_W'(count_d);
        end
      end
      ST_LIST: begin
        if (out_free) begin
          ctl.op       = OP_ROTATE;
          ctl.value    = cell_data[0];
          out_valid_d  = 1'b1;
          out_elem_d   = cell_data[0];
          out_status_d = STATUS_DONE;
          out_occ_d    = OCC_W'(count_q);
          out_last_d   = (remain_q == CNT_W'(1));
          remain_d     = remain_q - 1'b1;
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_elem_q   <= out_elem_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.element   = out_elem_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;
  assign out_o.last      = out_last_q;

  // occupied flags agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_occ) == 32'(count_q))
    else $error("cell occupancy does not match element count");

  // a running list always has elements left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (remain_q != '0))
    else $error("list running with nothing left");

  // no new item while a list is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> !in_i.ready)
    else $error("input taken during a list");

  // a push on a full queue leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full && (in_i.mode == MODE_PUSH_FRONT || in_i.mode == MODE_PUSH_BACK))
      |=> $stable(count_q))
    else $error("count changed on a dropped push");

endmodule

>>> dv/double_ended_queue_tb.sv
// testbench of the double-ended queue: directed table then biased random traffic
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  // codes that the block treats as no operation
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int unsigned RAND_OPS   = 180;
  localparam int unsigned PLAN_ROWS  = 25;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned DUE_DEPTH  = 256;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } result_t;

  // one row of the directed table; a typed row carries its own expected result
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic                     fresh_value;
    logic [7:0]               reps;
    logic                     typed;
    result_t                  want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  deq_in_if  in_if ();
  deq_out_if out_if ();

  double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // directed table: empty cases, unused codes, extremes, full queue, wrap
  plan_row_t plan [PLAN_ROWS] = '{
    '{MODE_POP_FRONT,  32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_EMPTY, 7'd0, 1'b1}},
    '{MODE_POP_BACK,   32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_EMPTY, 7'd0, 1'b1}},
    '{MODE_LIST,       32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_EMPTY, 7'd0, 1'b1}},
    '{MODE_SPARE_5,    32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd0, 1'b1}},
    '{MODE_SPARE_6,    32'h5a5a_a5a5,   1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd0, 1'b1}},
    '{MODE_SPARE_7,    32'hffff_ffff,   1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd0, 1'b1}},
    '{MODE_PUSH_FRONT, 32'h7fff_ffff,   1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd1, 1'b1}},
    '{MODE_PUSH_BACK,  32'h8000_0000,   1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd2, 1'b1}},
    '{MODE_PUSH_FRONT, 32'hffff_ffff,   1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd3, 1'b1}},
    '{MODE_PUSH_BACK,  32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd4, 1'b1}},
    '{MODE_LIST,       32'sd0,          1'b0, 8'd1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'sd0,          1'b0, 8'd1,  1'b1, '{32'hffff_ffff, STATUS_DONE, 7'd3, 1'b1}},
    '{MODE_POP_BACK,   32'sd0,          1'b0, 8'd1,  1'b0, '0},
    '{MODE_POP_BACK,   32'sd0,          1'b0, 8'd1,  1'b1, '{32'h8000_0000, STATUS_DONE, 7'd1, 1'b1}},
    '{MODE_POP_FRONT,  32'sd0,          1'b0, 8'd1,  1'b1, '{32'h7fff_ffff, STATUS_DONE, 7'd0, 1'b1}},
    '{MODE_POP_BACK,   32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_EMPTY, 7'd0, 1'b1}},
    '{MODE_PUSH_BACK,  32'sd0,          1'b1, 8'd63, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'sd0,          1'b1, 8'd1,  1'b0, '0},
    '{MODE_PUSH_FRONT, 32'sd7,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_FULL, 7'd64, 1'b1}},
    '{MODE_PUSH_BACK,  32'sd9,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_FULL, 7'd64, 1'b1}},
    '{MODE_LIST,       32'sd0,          1'b0, 8'd1,  1'b0, '0},
    '{MODE_POP_BACK,   32'sd0,          1'b0, 8'd32, 1'b0, '0},
    '{MODE_POP_FRONT,  32'sd0,          1'b0, 8'd32, 1'b0, '0},
    '{MODE_LIST,       32'sd0,          1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_EMPTY, 7'd0, 1'b1}},
    '{MODE_SPARE_5,    32'h8000_0001,   1'b0, 8'd1,  1'b1, '{32'sd0, STATUS_DONE,  7'd0, 1'b1}}
  };

  // shadow copy of the queue contents
  logic signed [DATA_W-1:0] slot_copy [CAPACITY];
  int unsigned head_pos = 0;
  int unsigned fill_cnt = 0;

  // results of one operation
  result_t     step_res [CAPACITY];
  int unsigned step_cnt = 0;

  // expected results in order, kept in a ring
  result_t     due_buf [DUE_DEPTH];
  int unsigned due_rd  = 0;
  int unsigned due_cnt = 0;

  int unsigned mismatch_cnt = 0;

  // what the item being offered should produce when it is a typed row
  logic    row_typed = 1'b0;
  result_t row_want  = '0;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  function automatic result_t make_result(logic signed [DATA_W-1:0] elem,
                                          logic [STATUS_W-1:0] stat, logic fin);
    result_t r;
    r.element   = elem;
    r.status    = stat;
    r.occupancy = OCC_W'(fill_cnt);
    r.last      = fin;
    return r;
  endfunction

  // append one result of the current operation
  function automatic void step_add(input result_t r);
    step_res[step_cnt] = r;
    step_cnt++;
  endfunction

  // append one expected result at the tail of the ring
  function automatic void due_add(input result_t r);
    due_buf[(due_rd + due_cnt) % DUE_DEPTH] = r;
    due_cnt++;
  endfunction

  // one operation on the shadow queue, results collected in step_res
  task automatic deque_model_step(input logic [MODE_W-1:0] op,
                                  input logic signed [DATA_W-1:0] word);
    logic signed [DATA_W-1:0] taken;
    step_cnt = 0;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_cnt >= CAPACITY) begin
          step_add(make_result('0, STATUS_FULL, 1'b1));
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            head_pos = (head_pos + CAPACITY - 1) % CAPACITY;
            slot_copy[head_pos] = word;
          end else begin
            slot_copy[(head_pos + fill_cnt) % CAPACITY] = word;
          end
          fill_cnt++;
          step_add(make_result('0, STATUS_DONE, 1'b1));
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (fill_cnt == 0) begin
          step_add(make_result('0, STATUS_EMPTY, 1'b1));
        end else begin
          if (op == MODE_POP_FRONT) begin
            taken = slot_copy[head_pos];
            head_pos = (head_pos + 1) % CAPACITY;
          end else begin
            taken = slot_copy[(head_pos + fill_cnt - 1) % CAPACITY];
          end
          fill_cnt--;
          step_add(make_result(taken, STATUS_DONE, 1'b1));
        end
      end
      MODE_LIST: begin
        if (fill_cnt == 0) begin
          step_add(make_result('0, STATUS_EMPTY, 1'b1));
        end else begin
          for (int unsigned k = 0; k < fill_cnt; k++) begin
            step_add(make_result(slot_copy[(head_pos + k) % CAPACITY],
                                 STATUS_DONE, k + 1 == fill_cnt));
          end
        end
      end
      default: begin
        step_add(make_result('0, STATUS_DONE, 1'b1));
      end
    endcase
  endtask

  // idle cycles before a transfer; calm stretches have none
  function automatic int unsigned idle_draw(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // push values lean on the extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'sd0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // offer one item and return at the falling edge after its transfer
  task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] word,
                         input logic typed, input result_t want);
    int unsigned gap;
    gap = idle_draw(tx_calm);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_typed        = typed;
    row_want         = want;
    in_if.mode       = op;
    in_if.push_value = word;
    in_if.valid      = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // hold the sender until every expected result has come back
  task automatic hold_until_drained();
    in_if.valid = 1'b0;
    while (due_cnt != 0) @(negedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // time limit
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        deque_model_step(in_if.mode, in_if.push_value);
        if (row_typed) due_add(row_want);
        else for (int unsigned k = 0; k < step_cnt; k++) due_add(step_res[k]);
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.element, out_if.status, out_if.occupancy, out_if.last};
        if (due_cnt == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result element %0d status %0d occupancy %0d last %0b",
                     $realtime, got.element, got.status, got.occupancy, got.last);
        end else begin
          want    = due_buf[due_rd];
          due_rd  = (due_rd + 1) % DUE_DEPTH;
          due_cnt--;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch expected element %0d status %0d occupancy %0d last %0b",
                       $realtime, want.element, want.status, want.occupancy, want.last);
              $display("%0t:          got element %0d status %0d occupancy %0d last %0b",
                       $realtime, got.element, got.status, got.occupancy, got.last);
            end
          end
        end
      end
    end
  end

  // result side: random stalls with calm stretches
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = idle_draw(rx_calm);
      if (gap != 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
    end
  end

  // reset, directed table, random traffic, drain
  initial begin
    int unsigned bias;
    int unsigned roll;
    logic [MODE_W-1:0] op;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_PUSH_FRONT;
    in_if.push_value = '0;
    rst_ni           = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      repeat (plan[r].reps)
        send_op(plan[r].mode, plan[r].fresh_value ? pick_value() : plan[r].value,
                plan[r].typed, plan[r].want);
    end

    // random phases lean toward filling, draining or a mix
    bias = 0;
    for (int unsigned n = 0; n < RAND_OPS; n++) begin
      if (n % 40 == 0) begin
        if (n != 0 && $urandom_range(0, 2) == 0) hold_until_drained();
        bias    = $urandom_range(0, 2);
        tx_calm = ($urandom_range(0, 2) == 0);
      end
      if (n == RAND_OPS / 2) hold_until_drained();
      roll = $urandom_range(0, 99);
      case (bias)
        0:       op = roll < 75 ? MODE_PUSH_FRONT : roll < 85 ? MODE_POP_FRONT :
                      roll < 95 ? MODE_LIST : MODE_SPARE_5;
        1:       op = roll < 20 ? MODE_PUSH_FRONT : roll < 85 ? MODE_POP_FRONT :
                      roll < 95 ? MODE_LIST : MODE_SPARE_5;
        default: op = roll < 45 ? MODE_PUSH_FRONT : roll < 85 ? MODE_POP_FRONT :
                      roll < 96 ? MODE_LIST : MODE_SPARE_5;
      endcase
      // choose front or back end, or one of the unused codes
      if (op == MODE_PUSH_FRONT && $urandom_range(0, 1) == 1) op = MODE_PUSH_BACK;
      if (op == MODE_POP_FRONT && $urandom_range(0, 1) == 1) op = MODE_POP_BACK;
      if (op == MODE_SPARE_5) op = MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      send_op(op, pick_value(), 1'b0, '0);
    end
    in_if.valid = 1'b0;

    while (due_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
